/* rtl/core/decimal_precision_square_root_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal-precision square root unit
// Clocked implication checks, gated off while reset is held.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_PRECISION_SQUARE_ROOT_UNIT_ASSERT_SVH
`define DECIMAL_PRECISION_SQUARE_ROOT_UNIT_ASSERT_SVH

// same-cycle implication
`define DPSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsr same-cycle check failed");

// next-cycle implication
`define DPSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsr next-cycle check failed");

`endif

/* rtl/core/dpsr_pkg.sv */
// ----------------------------------------------------------------------------
// dpsr_pkg
// Widths, limits and sequencer states of the decimal-precision square root.
// ----------------------------------------------------------------------------
package dpsr_pkg;

  localparam int IN_W       = 32;
  localparam int MAX_DIGITS = 4;
  localparam int CFG_W      = 3;
  localparam int HALF_W     = (IN_W + 1) / 2;
  localparam int BIT_IDX_W  = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int ROOT_W     = HALF_W + $clog2(10 ** MAX_DIGITS);
  localparam int TGT_W      = IN_W + $clog2(10 ** (2 * MAX_DIGITS));
  localparam int PROD_W     = 2 * ROOT_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ROOT_W + 7) / 8) * 8;
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam longint ROOT_MAX = (longint'(10) ** MAX_DIGITS) * (longint'(1) << HALF_W) - 1;
  localparam logic [CFG_W-1:0] DIGITS_RESET = CFG_W'(3);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INT_MUL,
    S_INT_CMP,
    S_DIG_SCALE,
    S_DIG_MUL,
    S_DIG_CMP,
    S_DONE
  } state_t;

endpackage

/* rtl/core/dpsr_sq.sv */
// ----------------------------------------------------------------------------
// dpsr_sq
// Shared registered squaring unit used for every trial of the search.
// ----------------------------------------------------------------------------
module dpsr_sq (
  input  logic                          clk,
  input  logic [dpsr_pkg::ROOT_W-1:0]   operand,
  output logic [dpsr_pkg::PROD_W-1:0]   square
);

  logic [dpsr_pkg::PROD_W-1:0] square_r;
  logic [dpsr_pkg::PROD_W-1:0] square_nxt;

  assign square_nxt = dpsr_pkg::PROD_W'(operand) * dpsr_pkg::PROD_W'(operand);

  always_ff @(posedge clk) begin
    square_r <= square_nxt;
  end

  assign square = square_r;

endmodule

/* rtl/core/decimal_precision_square_root_unit.sv */
// ----------------------------------------------------------------------------
// decimal_precision_square_root_unit
// Returns floor(sqrt(radicand) * 10^digits) for one radicand per word.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_tready is high only while the sequencer is
// idle. A word is taken in, then the integer part is found over 16 result bits
// (one squaring and one compare per result bit), then each decimal digit gets
// a scaling step and one squaring and compare per trial, n+1 trials where n
// (0..9) is the digit value; last the result loads the output register once
// it is empty or being taken. All trials share the one squaring unit.
// A finished result waits in its output register while the next word starts.
// Digit counts above 4 act as 4. Reset leaves the digit count at 3.
// ----------------------------------------------------------------------------
`include "decimal_precision_square_root_unit_assert.svh"

module decimal_precision_square_root_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dpsr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] radicand
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dpsr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [29:0] scaled_root, then zero pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dpsr_pkg::CFG_W-1:0]         cfg_data    // decimal_digits
);

  dpsr_pkg::state_t state_r, state_nxt;

  logic [dpsr_pkg::CFG_W-1:0]     digits_r, digits_nxt;
  logic [dpsr_pkg::DCNT_W-1:0]    dleft_r, dleft_nxt;
  logic [dpsr_pkg::BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [dpsr_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [dpsr_pkg::TGT_W-1:0]     target_r, target_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [dpsr_pkg::ROOT_W-1:0]    out_root_r, out_root_nxt;

  logic [dpsr_pkg::ROOT_W-1:0]    trial_bit;
  logic [dpsr_pkg::ROOT_W-1:0]    trial_int;
  logic [dpsr_pkg::ROOT_W-1:0]    trial_inc;
  logic [dpsr_pkg::ROOT_W-1:0]    sq_operand;
  logic [dpsr_pkg::PROD_W-1:0]    square;
  logic                           fits;
  logic                           in_accept;
  logic                           cfg_accept;
  logic [dpsr_pkg::DCNT_W-1:0]    digits_sat;

  dpsr_sq u_sq (
    .clk     (clk),
    .operand (sq_operand),
    .square  (square)
  );

  assign trial_bit  = dpsr_pkg::ROOT_W'(1) << bit_r;
  assign trial_int  = root_r | trial_bit;
  assign trial_inc  = root_r + dpsr_pkg::ROOT_W'(1);
  assign sq_operand = (state_r == dpsr_pkg::S_INT_MUL) ? trial_int : trial_inc;
  assign fits       = square <= dpsr_pkg::PROD_W'(target_r);

  assign in_tready  = (state_r == dpsr_pkg::S_IDLE);
  assign in_accept  = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;

  assign digits_sat = (digits_r > dpsr_pkg::CFG_W'(dpsr_pkg::MAX_DIGITS)) ?
                      dpsr_pkg::DCNT_W'(dpsr_pkg::MAX_DIGITS) :
                      dpsr_pkg::DCNT_W'(digits_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dpsr_pkg::OUT_TDATA_W'(out_root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpsr_pkg::S_IDLE;
      digits_r    <= dpsr_pkg::DIGITS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      digits_r    <= digits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dleft_r    <= dleft_nxt;
    bit_r      <= bit_nxt;
    root_r     <= root_nxt;
    target_r   <= target_nxt;
    out_root_r <= out_root_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = cfg_accept ? cfg_data : digits_r;
    dleft_nxt     = dleft_r;
    bit_nxt       = bit_r;
    root_nxt      = root_r;
    target_nxt    = target_r;
    out_root_nxt  = out_root_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    case (state_r)
      dpsr_pkg::S_IDLE: begin
        if (in_accept) begin
          target_nxt = dpsr_pkg::TGT_W'(in_tdata[dpsr_pkg::IN_W-1:0]);
          root_nxt   = '0;
          bit_nxt    = dpsr_pkg::BIT_IDX_W'(dpsr_pkg::HALF_W - 1);
          dleft_nxt  = digits_sat;
          state_nxt  = dpsr_pkg::S_INT_MUL;
        end
      end
      dpsr_pkg::S_INT_MUL: begin
        state_nxt = dpsr_pkg::S_INT_CMP;
      end
      dpsr_pkg::S_INT_CMP: begin
        if (fits) begin
          root_nxt = trial_int;
        end
        if (bit_r == '0) begin
          state_nxt = (dleft_r == '0) ? dpsr_pkg::S_DONE : dpsr_pkg::S_DIG_SCALE;
        end else begin
          bit_nxt   = bit_r - dpsr_pkg::BIT_IDX_W'(1);
          state_nxt = dpsr_pkg::S_INT_MUL;
        end
      end
      dpsr_pkg::S_DIG_SCALE: begin
        root_nxt   = (root_r << 3) + (root_r << 1);
        target_nxt = (target_r << 6) + (target_r << 5) + (target_r << 2);
        dleft_nxt  = dleft_r - dpsr_pkg::DCNT_W'(1);
        state_nxt  = dpsr_pkg::S_DIG_MUL;
      end
      dpsr_pkg::S_DIG_MUL: begin
        state_nxt = dpsr_pkg::S_DIG_CMP;
      end
      dpsr_pkg::S_DIG_CMP: begin
        if (fits) begin
          root_nxt  = trial_inc;
          state_nxt = dpsr_pkg::S_DIG_MUL;
        end else begin
          state_nxt = (dleft_r == '0) ? dpsr_pkg::S_DONE : dpsr_pkg::S_DIG_SCALE;
        end
      end
      dpsr_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_root_nxt  = root_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dpsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dpsr_pkg::S_IDLE;
      end
    endcase
  end

  `DPSR_ASSERT_SAME(a_out_range, clk, rst_n, out_valid_r,
    longint'(out_root_r) <= dpsr_pkg::ROOT_MAX)
  `DPSR_ASSERT_NEXT(a_start, clk, rst_n, in_accept,
    (state_r == dpsr_pkg::S_INT_MUL) && (root_r == '0))
  `DPSR_ASSERT_SAME(a_dleft, clk, rst_n, state_r != dpsr_pkg::S_IDLE,
    dleft_r <= dpsr_pkg::DCNT_W'(dpsr_pkg::MAX_DIGITS))

endmodule
